[rtl/core/cpl_pkg.sv]
// cpl_pkg: shared types and constants of the cascaded one-pole lowpass
// depends on nothing; imported by every module of the block
package cpl_pkg;

	localparam int STAGE_BITS = 24;
	localparam logic [16:0] COEF_ONE = 17'd65536;
	localparam logic [24:0] Q24_ONE = 25'd16777216;
	localparam logic [16:0] MIN_CUTOFF = 17'd10;
	localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
	// ceil(2^27/500): floor(fs/500) is (fs*BLEND_RECIP) >> 27 for any 18-bit fs
	localparam logic [18:0] BLEND_RECIP = 19'd268436;
	localparam logic [8:0] BLEND_MAX = 9'd511;
	localparam logic [17:0] FS_MIN = 18'd20;
	localparam int DIV_NW = 33;
	localparam int DIV_DW = 18;

	typedef enum logic [1:0] {
		OP_BASE = 2'd0,
		OP_CUT  = 2'd1,
		OP_BOTH = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_FS    = 2'd0,
		REG_CUT   = 2'd1,
		REG_POLES = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef enum logic {
		DSEL_T = 1'b0,
		DSEL_W = 1'b1
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_COEF, ST_DIV_T, ST_Y, ST_YP, ST_DIV_K, ST_E, ST_C,
		ST_PLAN, ST_DIV_F, ST_STG_MUL, ST_STG_ADD, ST_DIV_W, ST_ACC_MUL,
		ST_ACC_ADD, ST_FIN, ST_OUT
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic div_start;
		div_sel_t div_sel;
		logic load_t;
		logic load_y;
		logic load_yp;
		logic load_pk;
		logic load_e;
		logic load_c;
		logic c_one;
		logic plan;
		logic load_f;
		logic stg_mul;
		logic stg_add;
		logic load_w;
		logic acc_mul;
		logic acc_add;
		logic fin;
		logic out_load;
		logic [2:0] k;
	} cpl_cmd_t;

	typedef struct packed {
		logic bypass;
		logic blend_now;
		logic new_now;
		logic div_done;
		logic blend;
		logic left_nz;
		logic last;
		logic out_free;
	} cpl_sts_t;

	// exp(-pi*hi/8) in Q24
	function automatic logic [24:0] exp_tab(input logic [2:0] hi);
		logic [24:0] v;
		case (hi)
			3'd0: v = 25'd16777216;
			3'd1: v = 25'd11328511;
			3'd2: v = 25'd7649372;
			3'd3: v = 25'd5165100;
			3'd4: v = 25'd3487641;
			3'd5: v = 25'd2354966;
			3'd6: v = 25'd1590148;
			3'd7: v = 25'd1073719;
			default: v = 25'd16777216;
		endcase
		return v;
	endfunction

	// ceil(2^27/k): exact floor(v/k) as (v*r) >> 27 for any v below 2^24
	function automatic logic [27:0] recip_k(input logic [2:0] k);
		logic [27:0] r;
		case (k)
			3'd2: r = 28'd67108864;
			3'd3: r = 28'd44739243;
			3'd4: r = 28'd33554432;
			3'd5: r = 28'd26843546;
			3'd6: r = 28'd22369622;
			default: r = 28'd134217728;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/cascaded_one_pole_lowpass_top.sv]
// cascaded_one_pole_lowpass_top: top level of the cascaded one-pole lowpass
// depends on cpl_pkg, cpl_ctrl, cpl_dp (and cpl_div below it)
//
// usage
// - input channel: in_valid/in_stall carries one transaction per audio sample
//   with op, sample_in, mod_cutoff_hz and mod_pole_count
// - output channel: out_valid/out_stall returns exactly one filtered sample
//   per input transaction, in order
// - config port: cfg_we/cfg_idx/cfg_data writes sample rate (0), base cutoff (1)
//   and base pole count (2); write only while no transaction is in flight
// - one item at a time: in_stall is high from acceptance until the result
//   moves into the output register
// - the coefficient needs one 33-bit quotient of the serial divider and six
//   series steps; both are skipped when the cutoff is at or above Nyquist
//   or the sample rate is at most FS_MIN; each stage takes a multiply step
//   and an add step
// - crossfading items add a blend length step when the requested pole count
//   differs from the active one and, per stage, a divider quotient for the
//   weight step while the crossfade has items left
// - the output register holds a finished result while the receiver stalls;
//   the next item is accepted meanwhile and waits only at its own end
// - reset clears the stage store, blend state and settings to their defaults
module cascaded_one_pole_lowpass_top import cpl_pkg::*; #(
	parameter int MAX_POLES   = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_idx,
	input  logic [17:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [16:0]                   mod_cutoff_hz,
	input  logic [2:0]                    mod_pole_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	localparam int IW = MAX_POLES > 1 ? $clog2(MAX_POLES) : 1;

	// command and status between sequencer and datapath
	cpl_cmd_t      cmd;
	cpl_sts_t      sts;
	logic [IW-1:0] idx;

	cpl_ctrl #(
		.MAX_POLES (MAX_POLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	cpl_dp #(
		.MAX_POLES   (MAX_POLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.op             (op),
		.sample_in      (sample_in),
		.mod_cutoff_hz  (mod_cutoff_hz),
		.mod_pole_count (mod_pole_count),
		.cmd            (cmd),
		.idx            (idx),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_out     (sample_out)
	);

	// an accepted transaction keeps the input closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accepted transaction");

	// a result only enters the output register when it is free
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register overwritten");

	// inputs are latched only on an accepted transaction
	a_latch_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_in |-> (in_valid && !in_stall))
		else $error("input latched without a transaction");
endmodule

[rtl/core/cpl_div.sv]
// cpl_div: shared restoring divider, one quotient bit per cycle
// depends on cpl_pkg
module cpl_div import cpl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);
	localparam int CW = $clog2(DIV_NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   rem_sh;
	logic              ge;
	logic [DIV_DW:0]   rem_sub;

	assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(DIV_NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[rtl/core/cpl_ctrl.sv]
// cpl_ctrl: sequencer of the lowpass, issues datapath commands
// depends on cpl_pkg
module cpl_ctrl import cpl_pkg::*; #(
	parameter int MAX_POLES = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cpl_sts_t  sts,
	output cpl_cmd_t  cmd,
	output logic [(MAX_POLES > 1 ? $clog2(MAX_POLES) : 1)-1:0] idx
);
	localparam int IW = MAX_POLES > 1 ? $clog2(MAX_POLES) : 1;

	state_t state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [2:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			k_q     <= 3'd6;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.k   = k_q;
		cmd.div_sel = DSEL_T;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = ST_COEF;
				end
			end
			ST_COEF: begin
				if (sts.bypass) begin
					cmd.c_one = 1'b1;
					state_d = ST_PLAN;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DSEL_T;
					state_d = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (sts.div_done) begin
					cmd.load_t = 1'b1;
					state_d = ST_Y;
				end
			end
			ST_Y: begin
				cmd.load_y = 1'b1;
				k_d = 3'd6;
				state_d = ST_YP;
			end
			ST_YP: begin
				cmd.load_yp = 1'b1;
				state_d = ST_DIV_K;
			end
			ST_DIV_K: begin
				cmd.load_pk = 1'b1;
				if (k_q == 3'd1) begin
					state_d = ST_E;
				end else begin
					k_d = k_q - 3'd1;
					state_d = ST_YP;
				end
			end
			ST_E: begin
				cmd.load_e = 1'b1;
				state_d = ST_C;
			end
			ST_C: begin
				cmd.load_c = 1'b1;
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				cmd.plan = 1'b1;
				idx_d = '0;
				if (sts.blend_now && sts.new_now) begin
					state_d = ST_DIV_F;
				end else begin
					state_d = ST_STG_MUL;
				end
			end
			ST_DIV_F: begin
				cmd.load_f = 1'b1;
				state_d = ST_STG_MUL;
			end
			ST_STG_MUL: begin
				cmd.stg_mul = 1'b1;
				state_d = ST_STG_ADD;
			end
			ST_STG_ADD: begin
				cmd.stg_add = 1'b1;
				if (sts.blend) begin
					if (sts.left_nz) begin
						cmd.div_start = 1'b1;
						cmd.div_sel = DSEL_W;
						state_d = ST_DIV_W;
					end else begin
						state_d = ST_ACC_MUL;
					end
				end else if (sts.last) begin
					state_d = ST_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = ST_STG_MUL;
				end
			end
			ST_DIV_W: begin
				cmd.div_sel = DSEL_W;
				if (sts.div_done) begin
					cmd.load_w = 1'b1;
					state_d = ST_ACC_MUL;
				end
			end
			ST_ACC_MUL: begin
				cmd.acc_mul = 1'b1;
				state_d = ST_ACC_ADD;
			end
			ST_ACC_ADD: begin
				cmd.acc_add = 1'b1;
				if (sts.last) begin
					state_d = ST_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = ST_STG_MUL;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign idx = idx_q;
endmodule

[rtl/core/cpl_dp.sv]
// cpl_dp: datapath of the lowpass: settings, coefficient series, stages, blend
// depends on cpl_pkg and cpl_div
module cpl_dp import cpl_pkg::*; #(
	parameter int MAX_POLES   = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_idx,
	input  logic [17:0]            cfg_data,
	input  logic [1:0]             op,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [16:0]            mod_cutoff_hz,
	input  logic [2:0]             mod_pole_count,
	input  cpl_cmd_t               cmd,
	input  logic [(MAX_POLES > 1 ? $clog2(MAX_POLES) : 1)-1:0] idx,
	output cpl_sts_t               sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	localparam int PW = $clog2(MAX_POLES + 1);
	localparam int G = STAGE_BITS - SAMPLE_BITS;
	localparam int ACC_W = 42 + $clog2(MAX_POLES) + 1;
	localparam int RST_POLES = MAX_POLES < 2 ? MAX_POLES : 2;

	// settings and blend state
	logic [17:0]   fs_q;
	logic [16:0]   base_fc_q;
	logic [PW-1:0] base_poles_q;
	logic [PW-1:0] active_q;
	logic [8:0]    left_q;
	logic [16:0]   w_q [MAX_POLES];
	logic signed [STAGE_BITS-1:0] st_q [MAX_POLES];

	// per-item registers
	op_t           op_q;
	logic signed [STAGE_BITS-1:0] x_q;
	logic [16:0]   fc_q;
	logic [PW-1:0] mp_q;
	logic [14:0]   t_q;
	logic [22:0]   y_q;
	logic [23:0]   ypk_q;
	logic [24:0]   p_q;
	logic [24:0]   e_q;
	logic [16:0]   c_q;
	logic          blend_q;
	logic signed [STAGE_BITS-1:0] cur_q;
	logic signed [42:0] prod_q;
	logic signed [41:0] accp_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic          out_valid_q;

	function automatic logic [PW-1:0] clamp_poles(input logic [2:0] p);
		logic [PW-1:0] r;
		if (p == 3'd0)
			r = PW'(1);
		else if (4'(p) > 4'(MAX_POLES))
			r = PW'(MAX_POLES);
		else
			r = PW'(p);
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat(
		input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic signed [SAMPLE_BITS-1:0] r;
		hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
		lo = -hi - ACC_W'(1);
		if (v > hi)
			r = hi[SAMPLE_BITS-1:0];
		else if (v < lo)
			r = lo[SAMPLE_BITS-1:0];
		else
			r = v[SAMPLE_BITS-1:0];
		return r;
	endfunction

	// coefficient helpers
	logic [16:0] fc_cl;
	logic [38:0] y_prod;
	logic [47:0] yp_prod;
	logic [51:0] kq_prod;
	logic [49:0] e_prod;
	logic [25:0] c_sum;
	logic [16:0] c_calc;
	assign fc_cl   = (fc_q < MIN_CUTOFF) ? MIN_CUTOFF : fc_q;
	assign y_prod  = 39'(t_q[11:0]) * 39'(TWO_PI_Q24);
	assign yp_prod = 48'(y_q) * 48'(p_q);
	// series step divide by k through its reciprocal
	assign kq_prod = 52'(ypk_q) * 52'(recip_k(cmd.k));
	assign e_prod  = 50'(exp_tab(t_q[14:12])) * 50'(p_q);
	assign c_sum   = 26'(Q24_ONE) - 26'(e_q) + 26'd128;
	assign c_calc  = (c_sum[25:8] > 18'(COEF_ONE)) ? COEF_ONE : c_sum[24:8];

	// divider
	logic [DIV_NW-1:0] dvd;
	logic [DIV_DW-1:0] dvs;
	logic              div_done;
	logic [DIV_NW-1:0] quo;

	// blend weight step
	logic [16:0] target;
	logic        w_up;
	logic [16:0] w_diff;
	assign target = (PW'(idx) + PW'(1) == mp_q) ? COEF_ONE : 17'd0;
	assign w_up   = target >= w_q[idx];
	assign w_diff = w_up ? target - w_q[idx] : w_q[idx] - target;

	always_comb begin
		case (cmd.div_sel)
			DSEL_T: begin
				dvd = {fc_cl, 16'd0};
				dvs = fs_q;
			end
			DSEL_W: begin
				dvd = DIV_NW'(w_diff);
				dvs = DIV_DW'(left_q);
			end
			default: begin
				dvd = '0;
				dvs = '1;
			end
		endcase
	end

	cpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	// stage arithmetic
	logic signed [24:0] d;
	logic signed [42:0] prod_rnd;
	logic signed [27:0] st_new;
	assign d        = 25'(cur_q) - 25'(st_q[idx]);
	assign prod_rnd = (prod_q + 43'sd32768) >>> 16;
	assign st_new   = 28'(st_q[idx]) + prod_rnd[27:0];

	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] cur_rnd;
	assign acc_rnd = (acc_q + (ACC_W'(1) <<< (15 + G))) >>> (16 + G);
	assign cur_rnd = (ACC_W'(cur_q) + (G > 0 ? (ACC_W'(1) <<< (G > 0 ? G - 1 : 0))
		: ACC_W'(0))) >>> G;

	// blend length fs/500 through its reciprocal
	logic blend_now;
	logic [36:0] f_prod;
	logic [17:0] f_q18;
	assign blend_now = (op_q == OP_BOTH) &&
		!(mp_q == base_poles_q && mp_q == active_q && left_q == 9'd0);
	assign f_prod = 37'(fs_q) * 37'(BLEND_RECIP);
	assign f_q18  = 18'(f_prod[36:27]);

	// control state: settings, blend, stage store, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q         <= 18'd48000;
			base_fc_q    <= 17'd1000;
			base_poles_q <= PW'(RST_POLES);
			active_q     <= PW'(RST_POLES);
			left_q       <= '0;
			for (int i = 0; i < MAX_POLES; i++) begin
				w_q[i]  <= (i + 1 == RST_POLES) ? COEF_ONE : 17'd0;
				st_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_FS:  fs_q <= cfg_data;
					REG_CUT: base_fc_q <= cfg_data[16:0];
					REG_POLES: begin
						base_poles_q <= clamp_poles(cfg_data[2:0]);
						active_q     <= clamp_poles(cfg_data[2:0]);
						left_q       <= '0;
						for (int i = 0; i < MAX_POLES; i++)
							w_q[i] <= (PW'(i + 1) == clamp_poles(cfg_data[2:0]))
								? COEF_ONE : 17'd0;
					end
					default: ;
				endcase
			end
			if (cmd.plan && blend_now && mp_q != active_q)
				active_q <= mp_q;
			if (cmd.load_f) begin
				if (f_q18 == 18'd0)
					left_q <= 9'd1;
				else if (f_q18 > 18'(BLEND_MAX))
					left_q <= BLEND_MAX;
				else
					left_q <= f_q18[8:0];
			end
			if (cmd.stg_add)
				st_q[idx] <= st_new[STAGE_BITS-1:0];
			if (cmd.load_w)
				w_q[idx] <= w_up ? w_q[idx] + quo[16:0] : w_q[idx] - quo[16:0];
			if (cmd.fin && blend_q && left_q != 9'd0)
				left_q <= left_q - 9'd1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= op_t'(op);
			x_q  <= STAGE_BITS'(sample_in) <<< G;
			fc_q <= (op_t'(op) == OP_CUT || op_t'(op) == OP_BOTH) ? mod_cutoff_hz : base_fc_q;
			mp_q <= clamp_poles(mod_pole_count);
		end
		if (cmd.load_t)
			t_q <= quo[14:0];
		if (cmd.load_y) begin
			y_q <= y_prod[38:16];
			p_q <= Q24_ONE;
		end
		if (cmd.load_yp)
			ypk_q <= yp_prod[47:24];
		if (cmd.load_pk)
			p_q <= Q24_ONE - 25'(kq_prod[50:27]);
		if (cmd.load_e)
			e_q <= e_prod[48:24];
		if (cmd.load_c)
			c_q <= c_calc;
		if (cmd.c_one)
			c_q <= COEF_ONE;
		if (cmd.plan) begin
			blend_q <= blend_now;
			cur_q   <= x_q;
			acc_q   <= '0;
		end
		if (cmd.stg_mul)
			prod_q <= $signed({1'b0, c_q}) * d;
		if (cmd.stg_add)
			cur_q <= st_new[STAGE_BITS-1:0];
		if (cmd.acc_mul)
			accp_q <= st_q[idx] * $signed({1'b0, w_q[idx]});
		if (cmd.acc_add)
			acc_q <= acc_q + ACC_W'(accp_q);
		if (cmd.fin)
			res_q <= blend_q ? sat(acc_rnd) : sat(cur_rnd);
		if (cmd.out_load)
			out_q <= res_q;
	end

	logic [PW-1:0] n_stages;
	assign n_stages = blend_q ? PW'(MAX_POLES) : base_poles_q;

	assign sts.bypass    = (fs_q <= FS_MIN) || ({1'b0, fc_q, 1'b0} >= {1'b0, fs_q});
	assign sts.blend_now = blend_now;
	assign sts.new_now   = mp_q != active_q;
	assign sts.div_done  = div_done;
	assign sts.blend     = blend_q;
	assign sts.left_nz   = left_q != 9'd0;
	assign sts.last      = (PW'(idx) + PW'(1)) == n_stages;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
endmodule
